@@ src/ipv6cks_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6cks_pkg
// Shared types and constants of the IPv6 upper-layer checksum engine.
// ----------------------------------------------------------------------------
package ipv6cks_pkg;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	// configuration register indexes
	localparam logic CFG_SRC_HIGH = 1'b0;
	localparam logic CFG_SRC_LOW  = 1'b1;

	localparam logic [7:0]  UDP_PROTO = 8'd17;
	localparam logic [15:0] ALL_ONES  = 16'hffff;

	// width of the partial pseudo-header sum carried by a seed entry
	localparam int unsigned PART_W = 20;

	// operations passed from the front to the back
	typedef enum logic [1:0] {
		OP_SEED,
		OP_ADD,
		OP_ERR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [PART_W-1:0] value;
		logic [7:0]        proto;
		logic              last;
	} entry_t;

endpackage : ipv6cks_pkg
`default_nettype wire

@@ src/ipv6_l4_checksum_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6_l4_checksum_top
// IPv6 upper-layer checksum engine with pseudo-header.
// ----------------------------------------------------------------------------
// Usage: write the source address through the config port (index 0 = upper
// 64 bits, index 1 = lower 64 bits) while no packet is in flight. Each input
// beat is either a start (command 0: destination address, next header and
// payload length) or one payload byte (command 1). Bytes pair big-endian;
// an odd last byte is padded low. One result beat follows the last byte of a
// packet, a zero-length start, or a start whose length exceeds MAX_PAYLOAD
// (then checksum 0 with length_error set). Bytes outside a packet are dropped.
// Throughput: one input beat per cycle while in_stall is low, set by the sum
// update in the back end. After the beat that finishes a packet, out_valid
// rises once its entry has passed the queue write and then the result register.
// A four-entry queue parts the front from the back; in_stall rises while it
// is full. While out_stall holds a result, the back keeps draining entries
// that produce no result, and stops at the next one that does.
// Reset clears framing state, the queue, the source address and out_valid.
// ----------------------------------------------------------------------------
module ipv6_l4_checksum_top #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [63:0] dest_addr_high,
	input  wire logic [63:0] dest_addr_low,
	input  wire logic [7:0]  next_header_code,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      checksum_value,
	output logic             length_error
);

	ipv6cks_pkg::entry_t push_entry;
	ipv6cks_pkg::entry_t head;
	logic                push;
	logic                pop;
	logic                empty;
	logic                full;
	logic                accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	ipv6cks_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.command         (command),
		.dest_addr_high  (dest_addr_high),
		.dest_addr_low   (dest_addr_low),
		.next_header_code(next_header_code),
		.payload_length  (payload_length),
		.data_byte       (data_byte),
		.push_entry      (push_entry),
		.push            (push)
	);

	ipv6cks_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	ipv6cks_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.checksum_value(checksum_value),
		.length_error  (length_error)
	);

endmodule : ipv6_l4_checksum_top
`default_nettype wire

@@ src/ipv6cks_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6cks_front
// Accepts input beats, tracks packet framing and byte pairing, and turns
// each beat into at most one queue entry for the back end.
// ----------------------------------------------------------------------------
module ipv6cks_front #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic                 command,
	input  wire logic [63:0]          dest_addr_high,
	input  wire logic [63:0]          dest_addr_low,
	input  wire logic [7:0]           next_header_code,
	input  wire logic [15:0]          payload_length,
	input  wire logic [7:0]           data_byte,
	output ipv6cks_pkg::entry_t       push_entry,
	output logic                      push
);

	localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

	logic        active_q;
	logic [15:0] left_q;
	logic        odd_q;
	logic [7:0]  held_q;

	logic [ipv6cks_pkg::PART_W-1:0] dest_part;
	logic                           len_over;

	// sum destination words, length and next header without folding
	assign dest_part =
		ipv6cks_pkg::PART_W'(dest_addr_high[63:48]) +
		ipv6cks_pkg::PART_W'(dest_addr_high[47:32]) +
		ipv6cks_pkg::PART_W'(dest_addr_high[31:16]) +
		ipv6cks_pkg::PART_W'(dest_addr_high[15:0]) +
		ipv6cks_pkg::PART_W'(dest_addr_low[63:48]) +
		ipv6cks_pkg::PART_W'(dest_addr_low[47:32]) +
		ipv6cks_pkg::PART_W'(dest_addr_low[31:16]) +
		ipv6cks_pkg::PART_W'(dest_addr_low[15:0]) +
		ipv6cks_pkg::PART_W'(payload_length) +
		ipv6cks_pkg::PART_W'(next_header_code);

	assign len_over = payload_length > MaxLen;

	// classify the beat into a queue entry
	always_comb begin
		push_entry.op    = ipv6cks_pkg::OP_ADD;
		push_entry.value = '0;
		push_entry.proto = next_header_code;
		push_entry.last  = 1'b0;
		push             = 1'b0;
		if (accept) begin
			if (command == ipv6cks_pkg::CMD_START) begin
				push = 1'b1;
				if (len_over) begin
					push_entry.op   = ipv6cks_pkg::OP_ERR;
					push_entry.last = 1'b1;
				end else begin
					push_entry.op    = ipv6cks_pkg::OP_SEED;
					push_entry.value = dest_part;
					push_entry.last  = (payload_length == 16'd0);
				end
			end else if (active_q) begin
				if (!odd_q) begin
					if (left_q <= 16'd1) begin
						push             = 1'b1;
						push_entry.value = ipv6cks_pkg::PART_W'({data_byte, 8'h00});
						push_entry.last  = 1'b1;
					end
				end else begin
					push             = 1'b1;
					push_entry.value = ipv6cks_pkg::PART_W'({held_q, data_byte});
					push_entry.last  = (left_q == 16'd1);
				end
			end
		end
	end

	// advance framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= '0;
			odd_q    <= 1'b0;
			held_q   <= '0;
		end else if (accept) begin
			if (command == ipv6cks_pkg::CMD_START) begin
				odd_q  <= 1'b0;
				held_q <= '0;
				if (len_over) begin
					active_q <= 1'b0;
					left_q   <= '0;
				end else begin
					active_q <= (payload_length != 16'd0);
					left_q   <= payload_length;
				end
			end else if (active_q) begin
				if (!odd_q) begin
					if (left_q <= 16'd1) begin
						active_q <= 1'b0;
						left_q   <= '0;
					end else begin
						held_q <= data_byte;
						odd_q  <= 1'b1;
						left_q <= left_q - 16'd1;
					end
				end else begin
					odd_q  <= 1'b0;
					left_q <= left_q - 16'd1;
					if (left_q == 16'd1) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule : ipv6cks_front
`default_nettype wire

@@ src/ipv6cks_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6cks_fifo
// Short entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module ipv6cks_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire ipv6cks_pkg::entry_t push_entry,
	input  wire logic                pop,
	output ipv6cks_pkg::entry_t      head,
	output logic                     empty,
	output logic                     full
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	ipv6cks_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule : ipv6cks_fifo
`default_nettype wire

@@ src/ipv6cks_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv6cks_back
// Holds the source address, runs the end-around-carry sum over queue
// entries and drives the registered result channel.
// ----------------------------------------------------------------------------
module ipv6cks_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_index,
	input  wire logic [63:0]         cfg_data,
	input  wire ipv6cks_pkg::entry_t head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [15:0]              checksum_value,
	output logic                     length_error
);

	logic [63:0] src_high_q;
	logic [63:0] src_low_q;
	logic [15:0] running_sum_q;
	logic [7:0]  proto_q;
	logic        out_valid_q;
	logic [15:0] checksum_q;
	logic        length_error_q;

	logic [20:0] seed_total;
	logic [16:0] seed_fold1;
	logic [15:0] seed_sum;
	logic [16:0] add_raw;
	logic [15:0] add_sum;
	logic [15:0] new_sum;
	logic [7:0]  new_proto;
	logic [15:0] cs_inv;
	logic [15:0] cs_final;
	logic        out_free;

	// write source address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_high_q <= '0;
			src_low_q  <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == ipv6cks_pkg::CFG_SRC_HIGH) begin
				src_high_q <= cfg_data;
			end else begin
				src_low_q <= cfg_data;
			end
		end
	end

	// seed: source words plus the partial sum from the front, folded twice
	assign seed_total =
		21'(src_high_q[63:48]) + 21'(src_high_q[47:32]) +
		21'(src_high_q[31:16]) + 21'(src_high_q[15:0]) +
		21'(src_low_q[63:48])  + 21'(src_low_q[47:32]) +
		21'(src_low_q[31:16])  + 21'(src_low_q[15:0]) +
		21'(head.value);
	assign seed_fold1 = 17'(seed_total[15:0]) + 17'(seed_total[20:16]);
	assign seed_sum   = seed_fold1[15:0] + 16'(seed_fold1[16]);

	// one word with end-around carry
	assign add_raw = 17'(running_sum_q) + 17'(head.value[15:0]);
	assign add_sum = add_raw[15:0] + 16'(add_raw[16]);

	assign new_sum   = (head.op == ipv6cks_pkg::OP_SEED) ? seed_sum : add_sum;
	assign new_proto = (head.op == ipv6cks_pkg::OP_SEED) ? head.proto : proto_q;

	// complement, with zero sent as all ones for UDP
	assign cs_inv   = ~new_sum;
	assign cs_final = ((cs_inv == 16'd0) && (new_proto == ipv6cks_pkg::UDP_PROTO)) ?
		ipv6cks_pkg::ALL_ONES : cs_inv;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !empty && (!head.last || out_free);

	// hold the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			proto_q       <= '0;
		end else if (pop) begin
			case (head.op)
				ipv6cks_pkg::OP_SEED: begin
					running_sum_q <= seed_sum;
					proto_q       <= head.proto;
				end
				ipv6cks_pkg::OP_ADD: begin
					running_sum_q <= add_sum;
				end
				default: begin
					running_sum_q <= '0;
					proto_q       <= head.proto;
				end
			endcase
		end
	end

	// result register: load a finished beat, drop a taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			if (head.op == ipv6cks_pkg::OP_ERR) begin
				checksum_q     <= '0;
				length_error_q <= 1'b1;
			end else begin
				checksum_q     <= cs_final;
				length_error_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign checksum_value = checksum_q;
	assign length_error   = length_error_q;

endmodule : ipv6cks_back
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv6 upper-layer checksum engine. A directed
// table covers empty, over-limit, UDP zero-replacement, odd-length and
// abandoned packets. Random packets then run under several idle and stall
// mixes and source addresses. Every accepted input beat goes through an
// in-bench checksum predictor, and each result beat is compared in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned MAX_PAYLOAD   = 1024;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_ICMP6   = 8'd58;
	localparam logic [63:0] ONES64        = '1;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_ITEMS   = 125;
	localparam int unsigned LONG_BYTES    = 32;

	typedef struct packed {
		logic        cmd;
		logic [63:0] dh;
		logic [63:0] dl;
		logic [7:0]  nh;
		logic [15:0] len;
		logic [7:0]  data;
	} beat_t;

	typedef struct packed {
		logic [15:0] checksum;
		logic        err;
	} sum_result_t;

	typedef struct {
		beat_t       beat;
		bit          pinned;
		sum_result_t result;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [63:0] dest_addr_high;
	logic [63:0] dest_addr_low;
	logic [7:0]  next_header_code;
	logic [15:0] payload_length;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] checksum_value;
	logic        length_error;

	// typed-in expectation that travels with a directed beat
	logic        pin_on;
	sum_result_t pin_value;

	// predictor copy of the engine
	logic [63:0] src_high   = '0;
	logic [63:0] src_low    = '0;
	logic [15:0] run_sum    = '0;
	logic [15:0] left_count = '0;
	logic [7:0]  held_byte  = '0;
	logic [7:0]  cur_proto  = '0;
	logic        odd_half   = 1'b0;
	logic        pkt_open   = 1'b0;

	sum_result_t checksum_q[$];
	plan_row_t   directed_rows[$];

	int          errors          = 0;
	int          beats_accepted  = 0;
	int          results_checked = 0;
	int          over_limit_seen = 0;
	int          src_writes      = 0;
	int          abandoned       = 0;
	int unsigned items_sent      = 0;
	int unsigned idle_pct        = 0;
	int unsigned stall_pct       = 0;
	int unsigned hold_requests   = 0;
	int unsigned holds_served    = 0;

	ipv6_l4_checksum_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// end-around-carry add of one 16-bit word
	function automatic logic [15:0] oc_add16(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, word};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic logic [15:0] oc_add64(input logic [15:0] acc, input logic [63:0] v);
		logic [15:0] a;
		a = acc;
		for (int i = 3; i >= 0; i--)
			a = oc_add16(a, v[i*16 +: 16]);
		return a;
	endfunction

	// complement the sum, apply the UDP zero rule, close the packet
	function automatic sum_result_t close_packet();
		sum_result_t r;
		r.checksum = ~run_sum;
		r.err = 1'b0;
		if (r.checksum == 16'd0 && cur_proto == ipv6cks_pkg::UDP_PROTO)
			r.checksum = ipv6cks_pkg::ALL_ONES;
		pkt_open = 1'b0;
		odd_half = 1'b0;
		left_count = '0;
		return r;
	endfunction

	// advance the predictor by one beat; returns 1 when a result is due
	function automatic bit predict_checksum(input beat_t b, output sum_result_t r);
		logic [15:0] acc;
		r = '0;
		if (b.cmd == ipv6cks_pkg::CMD_START) begin
			pkt_open = 1'b0;
			odd_half = 1'b0;
			held_byte = '0;
			left_count = '0;
			cur_proto = b.nh;
			if (b.len > MAX_PAYLOAD) begin
				run_sum = '0;
				r.err = 1'b1;
				return 1'b1;
			end
			acc = oc_add64(16'd0, src_high);
			acc = oc_add64(acc, src_low);
			acc = oc_add64(acc, b.dh);
			acc = oc_add64(acc, b.dl);
			acc = oc_add16(acc, b.len);
			acc = oc_add16(acc, {8'd0, b.nh});
			run_sum = acc;
			if (b.len == 16'd0) begin
				r = close_packet();
				return 1'b1;
			end
			left_count = b.len;
			pkt_open = 1'b1;
			return 1'b0;
		end
		if (!pkt_open)
			return 1'b0;
		if (!odd_half) begin
			if (left_count <= 16'd1) begin
				run_sum = oc_add16(run_sum, {b.data, 8'd0});
				r = close_packet();
				return 1'b1;
			end
			held_byte = b.data;
			odd_half = 1'b1;
			left_count = left_count - 16'd1;
			return 1'b0;
		end
		run_sum = oc_add16(run_sum, {held_byte, b.data});
		odd_half = 1'b0;
		left_count = left_count - 16'd1;
		if (left_count == 16'd0) begin
			r = close_packet();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly random, now and then all zeros or all ones
	function automatic logic [63:0] pick_addr();
		case ($urandom_range(15))
			0: return '0;
			1: return ONES64;
			default: return rand64();
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// unused fields of a beat carry random junk
	function automatic beat_t start_beat(input logic [63:0] dh, input logic [63:0] dl,
			input logic [7:0] nh, input logic [15:0] len);
		beat_t b;
		b.cmd = ipv6cks_pkg::CMD_START;
		b.dh = dh;
		b.dl = dl;
		b.nh = nh;
		b.len = len;
		b.data = 8'($urandom_range(255));
		return b;
	endfunction

	function automatic beat_t byte_beat(input logic [7:0] data);
		beat_t b;
		b.cmd = ipv6cks_pkg::CMD_BYTE;
		b.dh = rand64();
		b.dl = rand64();
		b.nh = 8'($urandom_range(255));
		b.len = 16'($urandom_range(65535));
		b.data = data;
		return b;
	endfunction

	function automatic void add_row(input beat_t b, input bit pinned, input logic [15:0] cs,
			input logic err);
		plan_row_t row;
		row.beat = b;
		row.pinned = pinned;
		row.result.checksum = cs;
		row.result.err = err;
		directed_rows.push_back(row);
	endfunction

	// offer one beat after a random gap and hold it until taken
	task automatic drive_beat(input beat_t b, input bit pinned, input sum_result_t expv);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= b.cmd;
		dest_addr_high <= b.dh;
		dest_addr_low <= b.dl;
		next_header_code <= b.nh;
		payload_length <= b.len;
		data_byte <= b.data;
		pin_on <= pinned;
		pin_value <= expv;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, wait out every result, then let trailing beats drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (checksum_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_source(input logic [63:0] hi, input logic [63:0] lo);
		cfg_wr_en <= 1'b1;
		cfg_index <= ipv6cks_pkg::CFG_SRC_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= ipv6cks_pkg::CFG_SRC_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one packet with random content, sometimes cut short or preceded by noise
	task automatic send_random_packet();
		sum_result_t none;
		logic [7:0]  nh;
		int unsigned len;
		int unsigned cut;
		int unsigned pick;
		none = '0;
		if ($urandom_range(9) == 0)
			drive_beat(byte_beat(pick_byte()), 1'b0, none);
		case ($urandom_range(3))
			0: nh = ipv6cks_pkg::UDP_PROTO;
			1: nh = PROTO_TCP;
			2: nh = PROTO_ICMP6;
			default: nh = 8'($urandom_range(255));
		endcase
		pick = $urandom_range(99);
		if (pick < 6)
			len = 0;
		else if (pick < 14)
			len = $urandom_range(65535, MAX_PAYLOAD + 1);
		else if (pick < 20)
			len = $urandom_range(200, 25);
		else
			len = $urandom_range(24, 1);
		cut = ($urandom_range(19) == 0) ? $urandom_range(len) : len;
		drive_beat(start_beat(pick_addr(), pick_addr(), nh, 16'(len)), 1'b0, none);
		items_sent++;
		if (len <= MAX_PAYLOAD) begin
			for (int i = 0; i < cut; i++) begin
				drive_beat(byte_beat(pick_byte()), 1'b0, none);
				items_sent++;
			end
			if (cut < len)
				abandoned++;
		end
		if ($urandom_range(49) == 0)
			wait_idle();
	endtask

	// result side: random stall, plus long hold-offs on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// track config writes, predict accepted beats, check result beats
	always @(posedge clk) begin
		beat_t       seen;
		sum_result_t predicted;
		sum_result_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				if (cfg_index == ipv6cks_pkg::CFG_SRC_HIGH)
					src_high = cfg_data;
				else
					src_low = cfg_data;
				src_writes++;
			end
			if (in_valid && !in_stall) begin
				seen = {command, dest_addr_high, dest_addr_low, next_header_code,
					payload_length, data_byte};
				beats_accepted++;
				if (predict_checksum(seen, predicted)) begin
					checksum_q.push_back(pin_on ? pin_value : predicted);
					if (predicted.err)
						over_limit_seen++;
				end
			end
			if (out_valid && !out_stall) begin
				if (checksum_q.size() == 0) begin
					errors++;
					$error("result beat with none pending: checksum_value=%h length_error=%b",
						checksum_value, length_error);
				end else begin
					want = checksum_q.pop_front();
					results_checked++;
					if (checksum_value !== want.checksum) begin
						errors++;
						$error("checksum_value: expected %h, got %h", want.checksum,
							checksum_value);
					end
					if (length_error !== want.err) begin
						errors++;
						$error("length_error: expected %b, got %b", want.err, length_error);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		sum_result_t none;
		int unsigned phase_end;
		none = '0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= ipv6cks_pkg::CFG_SRC_HIGH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= ipv6cks_pkg::CMD_START;
		dest_addr_high <= '0;
		dest_addr_low <= '0;
		next_header_code <= '0;
		payload_length <= '0;
		data_byte <= '0;
		pin_on <= 1'b0;
		pin_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, source address still zero from reset
		add_row(byte_beat(8'ha5), 1'b0, '0, 1'b0);
		add_row(start_beat('0, '0, 8'd0, 16'd0), 1'b1, 16'hffff, 1'b0);
		add_row(start_beat('0, '0, ipv6cks_pkg::UDP_PROTO, 16'(MAX_PAYLOAD + 1)), 1'b1,
			16'h0000, 1'b1);
		add_row(start_beat(ONES64, ONES64, 8'hff, 16'hffff), 1'b1, 16'h0000, 1'b1);
		// sum folds to all ones: UDP sends ffff, other protocols send zero
		add_row(start_beat({16'hffee, 48'd0}, '0, ipv6cks_pkg::UDP_PROTO, 16'd0), 1'b1,
			16'hffff, 1'b0);
		add_row(start_beat({16'hffef, 48'd0}, '0, 8'd16, 16'd0), 1'b1, 16'h0000, 1'b0);
		add_row(start_beat(ONES64, ONES64, 8'hff, 16'd0), 1'b1, 16'hff00, 1'b0);
		// single odd byte, padded low
		add_row(start_beat('0, '0, PROTO_TCP, 16'd1), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'hff), 1'b0, '0, 1'b0);
		add_row(start_beat(64'h0123456789abcdef, 64'hfedcba9876543210,
			ipv6cks_pkg::UDP_PROTO, 16'd2), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h12), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h34), 1'b0, '0, 1'b0);
		add_row(start_beat('0, '0, PROTO_ICMP6, 16'd3), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h00), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'hff), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h80), 1'b0, '0, 1'b0);
		// restart abandons an open packet
		add_row(start_beat('0, '0, PROTO_TCP, 16'd5), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h11), 1'b0, '0, 1'b0);
		add_row(start_beat(ONES64, '0, PROTO_ICMP6, 16'd2), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'hfe), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h01), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h55), 1'b0, '0, 1'b0);
		// over-limit start while a packet is open, then a stray byte
		add_row(start_beat('0, '0, PROTO_TCP, 16'd4), 1'b0, '0, 1'b0);
		add_row(byte_beat(8'h77), 1'b0, '0, 1'b0);
		add_row(start_beat('0, '0, 8'd0, 16'h8000), 1'b1, 16'h0000, 1'b1);
		add_row(byte_beat(8'h99), 1'b0, '0, 1'b0);
		foreach (directed_rows[i])
			drive_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].result);
		wait_idle();

		// longest legal length opens a packet that a restart then abandons,
		// followed by a full all-ones packet, all under an all-ones source
		write_source(ONES64, ONES64);
		drive_beat(start_beat(ONES64, ONES64, ipv6cks_pkg::UDP_PROTO, 16'(MAX_PAYLOAD)),
			1'b0, none);
		repeat (LONG_BYTES) drive_beat(byte_beat(8'hff), 1'b0, none);
		drive_beat(start_beat(ONES64, ONES64, ipv6cks_pkg::UDP_PROTO, 16'(LONG_BYTES)),
			1'b0, none);
		repeat (LONG_BYTES) drive_beat(byte_beat(8'hff), 1'b0, none);

		// random phases, each with its own source address and idle mix
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					write_source(rand64(), rand64());
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					write_source('0, ONES64);
					idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					write_source(rand64(), rand64());
					idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					write_source(ONES64, '0);
					idle_pct = 32;
					stall_pct = 32;
				end
			endcase
			// hold results back while empty packets keep coming, to back up the queue
			if (ph == 0) begin
				hold_requests++;
				repeat (24) begin
					drive_beat(start_beat(rand64(), rand64(), PROTO_TCP, 16'd0), 1'b0, none);
					items_sent++;
				end
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_packet();
		end
		wait_idle();

		$display("Run covered %0d accepted beats, %0d checked results, %0d source writes.",
			beats_accepted, results_checked, src_writes);
		$display("Included %0d over-limit starts and %0d abandoned packets.",
			over_limit_seen, abandoned);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
